// ----- design/rss_pkg.sv -----
// Shared types and constants for the ratio summary statistics block.
// Word structs, controller states, command and status groups.
// No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

   localparam int RATIO_W   = 24;
   localparam int CNT_W     = 16;
   localparam int VALUE_W   = 32;
   localparam int NUM_RANKS = 8;

   localparam logic [3:0] MET_TOTAL  = 4'd0;
   localparam logic [3:0] MET_SUCC   = 4'd1;
   localparam logic [3:0] MET_RATE1  = 4'd2;
   localparam logic [3:0] MET_RATE2  = 4'd3;
   localparam logic [3:0] MET_MEAN   = 4'd4;
   localparam logic [3:0] MET_STD    = 4'd5;
   localparam logic [3:0] MET_MEDIAN = 4'd6;
   localparam logic [3:0] MET_MIN    = 4'd7;
   localparam logic [3:0] MET_MAX    = 4'd8;
   localparam logic [3:0] MET_Q1     = 4'd9;
   localparam logic [3:0] MET_Q3     = 4'd10;
   localparam logic [3:0] MET_PVAL   = 4'd11;
   localparam logic [3:0] MET_EFFECT = 4'd12;

   localparam logic [2:0] RANK_MIN   = 3'd0;
   localparam logic [2:0] RANK_MAX   = 3'd1;
   localparam logic [2:0] RANK_MED_A = 3'd2;
   localparam logic [2:0] RANK_MED_B = 3'd3;
   localparam logic [2:0] RANK_Q1_A  = 3'd4;
   localparam logic [2:0] RANK_Q1_B  = 3'd5;
   localparam logic [2:0] RANK_Q3_A  = 3'd6;
   localparam logic [2:0] RANK_Q3_B  = 3'd7;

   typedef struct packed {
      logic                 clustered_ok;
      logic                 grid_ok;
      logic [RATIO_W-1:0]   ratio_value;
      logic                 last_item;
   } req_word_type;

   typedef struct packed {
      logic [3:0]           metric_code;
      logic signed [VALUE_W-1:0] metric_value;
      logic                 final_metric;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_DIV,
      ST_DIV_WAIT,
      ST_VAR_SCAN,
      ST_VAR_WAIT,
      ST_SQRT_WAIT,
      ST_SEL_INIT,
      ST_SEL_SCAN,
      ST_SEL_WAIT,
      ST_SEL_STORE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      JOB_RATE1,
      JOB_RATE2,
      JOB_MEAN,
      JOB_VAR,
      JOB_PVAL,
      JOB_EFFECT
   } div_job_type;

   typedef enum logic {
      SCAN_VAR,
      SCAN_COUNT
   } scan_mode_type;

   typedef struct packed {
      logic          load;
      logic          clear_run;
      logic          div_start;
      div_job_type   div_job;
      logic          clr_std;
      logic          clr_eff;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          sel_init;
      logic          sel_store;
      logic [2:0]    rank;
      logic [4:0]    bit_idx;
      logic [3:0]    metric;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic scan_done;
      logic n_zero;
      logic n_lt2;
      logic s_zero;
   } status_type;

endpackage

// ----- design/rss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- design/rss_datapath.sv -----
// Datapath: run counters, sample RAM, serial divider, serial square root,
// scan engine for variance and radix rank selection, metric registers.
// Depends on rss_pkg and rss_ram.
`timescale 1ns / 1ps

module rss_datapath #(
   parameter int MAX_SAMPLES = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rss_pkg::cmd_type      cmd,
   input  rss_pkg::req_word_type req_word,
   output rss_pkg::status_type   status,
   output rss_pkg::rsp_word_type rsp_word
);

   localparam int NW    = $clog2(MAX_SAMPLES + 1);
   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int RW    = rss_pkg::RATIO_W;
   localparam int CW    = rss_pkg::CNT_W;
   localparam int SUM_W = RW + NW;
   localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
   localparam logic [RW:0] ONE_R = (RW + 1)'(ONE64);
   localparam logic [31:0] ONE32 = 32'(ONE64);
   localparam logic [31:0] NEG_ONE = 32'(64'd0 - ONE64);
   localparam logic [NW-1:0] MAX_N = NW'(MAX_SAMPLES);
   localparam logic [CW-1:0] CNT_MAX = '1;

   // run counters
   logic [CW-1:0]    exp_ff, w1_ff, w2_ff;
   logic [NW-1:0]    n_ff, above_ff;
   logic [SUM_W-1:0] sum_ff;
   logic             qualify;

   // divider
   logic              div_busy_ff, div_fin_ff;
   logic [5:0]        div_cnt_ff;
   logic [63:0]       dvd_ff;
   logic [31:0]       rem_ff, dvs_ff;
   rss_pkg::div_job_type job_ff;
   logic [32:0]       rem_sh;
   logic              rem_ge;
   logic [63:0]       dvd_sel;
   logic [31:0]       dvs_sel;
   logic [31:0]       quo_sat;

   // square root
   logic        sq_busy_ff, sq_fin_ff;
   logic [63:0] sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [63:0] sq_try, sq_v_in, sq_res_in;

   // scan engine
   logic                   scan_busy_ff, issue_ff, rdv_ff, prv_ff, match_ff;
   rss_pkg::scan_mode_type mode_ff;
   logic [NW-1:0]          addr_ff, cnt_ff, k_ff;
   logic [47:0]            prod_ff;
   logic [63:0]            m2_ff;
   logic [RW-1:0]          rd_data, prefix_ff;
   logic                   scan_done;
   logic signed [RW:0]     dev;
   logic signed [2*RW+1:0] dev_sq;
   logic [RW:0]            low_mask;
   logic [RW-1:0]          hi_mask;
   logic                   match;

   // metrics
   logic [31:0]   rate1_ff, rate2_ff, s_ff, p_ff, eff_ff;
   logic [RW-1:0] mean_ff;
   logic [RW-1:0] rank_ff [rss_pkg::NUM_RANKS];
   logic          eff_neg;
   logic [RW:0]   eff_mag;
   logic [NW-1:0] n_less_above, lesser;
   logic [NW-1:0] n_m1, half_n, lo1, lo3, rank_target;
   logic [NW+1:0] pos3;
   logic [1:0]    k1, k3;
   logic [RW:0]   med_sum;
   logic [31:0]   value;

   function automatic logic [RW-1:0] quart(input logic [RW-1:0] a, input logic [RW-1:0] b,
                                           input logic [1:0] k);
      logic [2:0]    wa;
      logic [RW+2:0] acc;
      wa  = 3'd4 - {1'b0, k};
      acc = (RW + 3)'(a) * (RW + 3)'(wa) + (RW + 3)'(b) * (RW + 3)'(k) + (RW + 3)'(2);
      return acc[RW+1:2];
   endfunction

   // ---------------- run counters and sample store
   assign qualify = cmd.load && req_word.clustered_ok && req_word.grid_ok &&
                    (req_word.ratio_value != '0) && (n_ff < MAX_N);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_run) begin
         exp_ff   <= '0;
         w1_ff    <= '0;
         w2_ff    <= '0;
         n_ff     <= '0;
         above_ff <= '0;
         sum_ff   <= '0;
      end else if (cmd.load) begin
         if (exp_ff != CNT_MAX) exp_ff <= exp_ff + CW'(1);
         if (req_word.clustered_ok && w1_ff != CNT_MAX) w1_ff <= w1_ff + CW'(1);
         if (req_word.grid_ok && w2_ff != CNT_MAX) w2_ff <= w2_ff + CW'(1);
         if (qualify) begin
            n_ff   <= n_ff + NW'(1);
            sum_ff <= sum_ff + SUM_W'(req_word.ratio_value);
            if ({1'b0, req_word.ratio_value} > ONE_R) above_ff <= above_ff + NW'(1);
         end
      end
   end

   rss_ram #(.WIDTH(RW), .DEPTH(MAX_SAMPLES)) u_ram (
      .clock   (clock),
      .wr_en   (qualify),
      .wr_addr (n_ff[AW-1:0]),
      .wr_data (req_word.ratio_value),
      .rd_en   (issue_ff),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // ---------------- divider operands
   assign eff_neg      = {1'b0, mean_ff} > ONE_R;
   assign eff_mag      = eff_neg ? ({1'b0, mean_ff} - ONE_R) : (ONE_R - {1'b0, mean_ff});
   assign n_less_above = n_ff - above_ff;
   assign lesser       = (above_ff < n_less_above) ? above_ff : n_less_above;
   assign half_n       = n_ff >> 1;

   always_comb begin
      dvd_sel = '0;
      dvs_sel = 32'd1;
      case (cmd.div_job)
         rss_pkg::JOB_RATE1: begin
            dvd_sel = (64'(w1_ff) << FRAC_BITS) + 64'(exp_ff >> 1);
            dvs_sel = 32'(exp_ff);
         end
         rss_pkg::JOB_RATE2: begin
            dvd_sel = (64'(w2_ff) << FRAC_BITS) + 64'(exp_ff >> 1);
            dvs_sel = 32'(exp_ff);
         end
         rss_pkg::JOB_MEAN: begin
            dvd_sel = 64'(sum_ff) + 64'(half_n);
            dvs_sel = 32'(n_ff);
         end
         rss_pkg::JOB_VAR: begin
            dvd_sel = m2_ff;
            dvs_sel = 32'(n_ff - NW'(1));
         end
         rss_pkg::JOB_PVAL: begin
            dvd_sel = (64'(lesser) << (FRAC_BITS + 1)) + 64'(half_n);
            dvs_sel = 32'(n_ff);
         end
         rss_pkg::JOB_EFFECT: begin
            dvd_sel = (64'(eff_mag) << FRAC_BITS) + 64'(s_ff >> 1);
            dvs_sel = s_ff;
         end
         default: begin
            dvd_sel = '0;
            dvs_sel = 32'd1;
         end
      endcase
   end

   // ---------------- restoring divider, one quotient bit per cycle
   assign rem_sh  = {rem_ff, dvd_ff[63]};
   assign rem_ge  = rem_sh >= {1'b0, dvs_ff};
   assign quo_sat = (dvd_ff[63:31] != '0) ? 32'h7FFF_FFFF : dvd_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_fin_ff  <= 1'b0;
      end else begin
         div_fin_ff <= div_busy_ff && (div_cnt_ff == '0);
         if (cmd.div_start) div_busy_ff <= 1'b1;
         else if (div_busy_ff && div_cnt_ff == '0) div_busy_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         dvd_ff     <= dvd_sel;
         dvs_ff     <= dvs_sel;
         rem_ff     <= '0;
         div_cnt_ff <= 6'd63;
         job_ff     <= cmd.div_job;
      end else if (div_busy_ff) begin
         rem_ff     <= rem_ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         dvd_ff     <= {dvd_ff[62:0], rem_ge};
         div_cnt_ff <= div_cnt_ff - 6'd1;
      end
   end

   // ---------------- metric registers written from quotients
   always_ff @(posedge clock) begin
      if (cmd.clr_eff) eff_ff <= '0;
      if (div_fin_ff) begin
         case (job_ff)
            rss_pkg::JOB_RATE1: rate1_ff <= quo_sat;
            rss_pkg::JOB_RATE2: rate2_ff <= quo_sat;
            rss_pkg::JOB_MEAN:  mean_ff  <= dvd_ff[RW-1:0];
            rss_pkg::JOB_PVAL:  p_ff     <= quo_sat;
            rss_pkg::JOB_EFFECT: begin
               if (!eff_neg) eff_ff <= quo_sat;
               else if (dvd_ff[63:31] != '0) eff_ff <= 32'h8000_0000;
               else eff_ff <= 32'(64'd0 - dvd_ff);
            end
            default: ;
         endcase
      end
   end

   // ---------------- square root, two radicand bits per cycle
   assign sq_try    = sq_res_ff + sq_bit_ff;
   assign sq_v_in   = (sq_v_ff >= sq_try) ? (sq_v_ff - sq_try) : sq_v_ff;
   assign sq_res_in = (sq_v_ff >= sq_try) ? ((sq_res_ff >> 1) + sq_bit_ff) : (sq_res_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_busy_ff <= 1'b0;
         sq_fin_ff  <= 1'b0;
      end else begin
         sq_fin_ff <= sq_busy_ff && sq_bit_ff[0];
         if (div_fin_ff && job_ff == rss_pkg::JOB_VAR) sq_busy_ff <= 1'b1;
         else if (sq_busy_ff && sq_bit_ff[0]) sq_busy_ff <= 1'b0;
      end
      if (div_fin_ff && job_ff == rss_pkg::JOB_VAR) begin
         sq_v_ff   <= dvd_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= 64'd1 << 62;
      end else if (sq_busy_ff) begin
         sq_v_ff   <= sq_v_in;
         sq_res_ff <= sq_res_in;
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.clr_std) s_ff <= '0;
      else if (sq_busy_ff && sq_bit_ff[0]) s_ff <= 32'(sq_res_in);
   end

   // ---------------- scan engine
   assign scan_done = scan_busy_ff && !issue_ff && !rdv_ff && !prv_ff;
   assign dev       = $signed({1'b0, rd_data}) - $signed({1'b0, mean_ff});
   assign dev_sq    = dev * dev;
   assign low_mask  = ((RW + 1)'(2) << cmd.bit_idx) - (RW + 1)'(1);
   assign hi_mask   = ~low_mask[RW-1:0];
   assign match     = (((rd_data ^ prefix_ff) & hi_mask) == '0) && !rd_data[cmd.bit_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_busy_ff <= 1'b0;
         issue_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         prv_ff       <= 1'b0;
      end else begin
         rdv_ff <= issue_ff;
         prv_ff <= rdv_ff;
         if (cmd.scan_start) begin
            scan_busy_ff <= 1'b1;
            issue_ff     <= 1'b1;
         end else begin
            if (scan_done) scan_busy_ff <= 1'b0;
            if (issue_ff && addr_ff == n_ff - NW'(1)) issue_ff <= 1'b0;
         end
      end
      if (cmd.scan_start) begin
         addr_ff <= '0;
         mode_ff <= cmd.scan_mode;
         m2_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         if (issue_ff) addr_ff <= addr_ff + NW'(1);
         if (prv_ff) begin
            if (mode_ff == rss_pkg::SCAN_VAR) m2_ff <= m2_ff + 64'(prod_ff);
            else if (match_ff) cnt_ff <= cnt_ff + NW'(1);
         end
      end
      if (rdv_ff) begin
         prod_ff  <= dev_sq[47:0];
         match_ff <= match;
      end
   end

   // ---------------- radix rank selection
   assign n_m1 = n_ff - NW'(1);
   assign pos3 = {1'b0, n_m1, 1'b0} + (NW + 2)'(n_m1);
   assign lo1  = n_m1 >> 2;
   assign k1   = n_m1[1:0];
   assign lo3  = pos3[NW+1:2];
   assign k3   = pos3[1:0];

   always_comb begin
      case (cmd.rank)
         rss_pkg::RANK_MIN:   rank_target = '0;
         rss_pkg::RANK_MAX:   rank_target = n_m1;
         rss_pkg::RANK_MED_A: rank_target = n_ff[0] ? half_n : half_n - NW'(1);
         rss_pkg::RANK_MED_B: rank_target = half_n;
         rss_pkg::RANK_Q1_A:  rank_target = lo1;
         rss_pkg::RANK_Q1_B:  rank_target = (k1 != '0) ? lo1 + NW'(1) : lo1;
         rss_pkg::RANK_Q3_A:  rank_target = lo3;
         rss_pkg::RANK_Q3_B:  rank_target = (k3 != '0) ? lo3 + NW'(1) : lo3;
         default:             rank_target = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.sel_init) begin
         k_ff      <= rank_target;
         prefix_ff <= '0;
      end else if (scan_done && mode_ff == rss_pkg::SCAN_COUNT) begin
         if (k_ff >= cnt_ff) begin
            prefix_ff <= prefix_ff | (RW'(1) << cmd.bit_idx);
            k_ff      <= k_ff - cnt_ff;
         end
      end
      if (cmd.sel_store) rank_ff[cmd.rank] <= prefix_ff;
   end

   // ---------------- result word
   assign med_sum = {1'b0, rank_ff[rss_pkg::RANK_MED_A]} + {1'b0, rank_ff[rss_pkg::RANK_MED_B]}
                    + (RW + 1)'(1);

   always_comb begin
      case (cmd.metric)
         rss_pkg::MET_TOTAL:  value = 32'(exp_ff);
         rss_pkg::MET_SUCC:   value = 32'(n_ff);
         rss_pkg::MET_RATE1:  value = rate1_ff;
         rss_pkg::MET_RATE2:  value = rate2_ff;
         rss_pkg::MET_MEAN:   value = (n_ff == '0) ? NEG_ONE : 32'(mean_ff);
         rss_pkg::MET_STD:    value = (n_ff == '0) ? NEG_ONE : s_ff;
         rss_pkg::MET_MEDIAN: value = (n_ff == '0) ? NEG_ONE : 32'(med_sum[RW:1]);
         rss_pkg::MET_MIN:    value = (n_ff == '0) ? NEG_ONE : 32'(rank_ff[rss_pkg::RANK_MIN]);
         rss_pkg::MET_MAX:    value = (n_ff == '0) ? NEG_ONE : 32'(rank_ff[rss_pkg::RANK_MAX]);
         rss_pkg::MET_Q1:     value = (n_ff == '0) ? NEG_ONE :
                                 32'(quart(rank_ff[rss_pkg::RANK_Q1_A],
                                           rank_ff[rss_pkg::RANK_Q1_B], k1));
         rss_pkg::MET_Q3:     value = (n_ff == '0) ? NEG_ONE :
                                 32'(quart(rank_ff[rss_pkg::RANK_Q3_A],
                                           rank_ff[rss_pkg::RANK_Q3_B], k3));
         rss_pkg::MET_PVAL:   value = (n_ff == '0) ? ONE32 : p_ff;
         rss_pkg::MET_EFFECT: value = (n_ff == '0) ? 32'd0 : eff_ff;
         default:             value = 32'd0;
      endcase
   end

   assign rsp_word.metric_code  = cmd.metric;
   assign rsp_word.metric_value = $signed(value);
   assign rsp_word.final_metric = (cmd.metric == rss_pkg::MET_EFFECT);

   assign status.div_done  = div_fin_ff;
   assign status.sqrt_done = sq_fin_ff;
   assign status.scan_done = scan_done;
   assign status.n_zero    = (n_ff == '0);
   assign status.n_lt2     = (n_ff < NW'(2));
   assign status.s_zero    = (s_ff == '0);

endmodule

// ----- design/rss_ctrl.sv -----
// Controller state machine: load phase, division jobs, scans, rank loop, emit.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  rss_pkg::status_type status,
   output rss_pkg::cmd_type    cmd
);

   rss_pkg::state_type   state_ff, state_in;
   rss_pkg::div_job_type job_ff, job_in;
   logic [3:0] code_ff, code_in;
   logic [2:0] rank_ff, rank_in;
   logic [4:0] bit_ff, bit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rss_pkg::ST_LOAD;
         job_ff   <= rss_pkg::JOB_RATE1;
         code_ff  <= rss_pkg::MET_TOTAL;
         rank_ff  <= rss_pkg::RANK_MIN;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         code_ff  <= code_in;
         rank_ff  <= rank_in;
         bit_ff   <= bit_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      code_in  = code_ff;
      rank_in  = rank_ff;
      bit_in   = bit_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd = '0;
      cmd.div_job   = job_ff;
      cmd.scan_mode = rss_pkg::SCAN_COUNT;
      cmd.rank      = rank_ff;
      cmd.bit_idx   = bit_ff;
      cmd.metric    = code_ff;
      case (state_ff)
         rss_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid && req_last) begin
               job_in   = rss_pkg::JOB_RATE1;
               code_in  = rss_pkg::MET_TOTAL;
               rank_in  = rss_pkg::RANK_MIN;
               state_in = rss_pkg::ST_DIV;
            end
         end
         rss_pkg::ST_DIV: begin
            cmd.div_start = 1'b1;
            state_in = rss_pkg::ST_DIV_WAIT;
         end
         rss_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               case (job_ff)
                  rss_pkg::JOB_RATE1: begin
                     job_in   = rss_pkg::JOB_RATE2;
                     state_in = rss_pkg::ST_DIV;
                  end
                  rss_pkg::JOB_RATE2: begin
                     if (status.n_zero) state_in = rss_pkg::ST_EMIT;
                     else begin
                        job_in   = rss_pkg::JOB_MEAN;
                        state_in = rss_pkg::ST_DIV;
                     end
                  end
                  rss_pkg::JOB_MEAN: begin
                     if (status.n_lt2) begin
                        cmd.clr_std = 1'b1;
                        state_in = rss_pkg::ST_SEL_INIT;
                     end else state_in = rss_pkg::ST_VAR_SCAN;
                  end
                  rss_pkg::JOB_VAR: state_in = rss_pkg::ST_SQRT_WAIT;
                  rss_pkg::JOB_PVAL: begin
                     if (status.s_zero) begin
                        cmd.clr_eff = 1'b1;
                        state_in = rss_pkg::ST_EMIT;
                     end else begin
                        job_in   = rss_pkg::JOB_EFFECT;
                        state_in = rss_pkg::ST_DIV;
                     end
                  end
                  default: state_in = rss_pkg::ST_EMIT;
               endcase
            end
         end
         rss_pkg::ST_VAR_SCAN: begin
            cmd.scan_start = 1'b1;
            cmd.scan_mode  = rss_pkg::SCAN_VAR;
            state_in = rss_pkg::ST_VAR_WAIT;
         end
         rss_pkg::ST_VAR_WAIT: begin
            cmd.scan_mode = rss_pkg::SCAN_VAR;
            if (status.scan_done) begin
               job_in   = rss_pkg::JOB_VAR;
               state_in = rss_pkg::ST_DIV;
            end
         end
         rss_pkg::ST_SQRT_WAIT: begin
            if (status.sqrt_done) state_in = rss_pkg::ST_SEL_INIT;
         end
         rss_pkg::ST_SEL_INIT: begin
            cmd.sel_init = 1'b1;
            bit_in   = 5'(rss_pkg::RATIO_W - 1);
            state_in = rss_pkg::ST_SEL_SCAN;
         end
         rss_pkg::ST_SEL_SCAN: begin
            cmd.scan_start = 1'b1;
            state_in = rss_pkg::ST_SEL_WAIT;
         end
         rss_pkg::ST_SEL_WAIT: begin
            if (status.scan_done) begin
               if (bit_ff == '0) state_in = rss_pkg::ST_SEL_STORE;
               else begin
                  bit_in   = bit_ff - 5'd1;
                  state_in = rss_pkg::ST_SEL_SCAN;
               end
            end
         end
         rss_pkg::ST_SEL_STORE: begin
            cmd.sel_store = 1'b1;
            if (rank_ff == rss_pkg::RANK_Q3_B) begin
               job_in   = rss_pkg::JOB_PVAL;
               state_in = rss_pkg::ST_DIV;
            end else begin
               rank_in  = rank_ff + 3'd1;
               state_in = rss_pkg::ST_SEL_INIT;
            end
         end
         rss_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (code_ff == rss_pkg::MET_EFFECT) begin
                  cmd.clear_run = 1'b1;
                  state_in = rss_pkg::ST_LOAD;
               end else code_in = code_ff + 4'd1;
            end
         end
         default: state_in = rss_pkg::ST_LOAD;
      endcase
   end

endmodule

// ----- design/ratio_summary_statistics.sv -----
// Top level of the ratio summary statistics block.
// Depends on rss_pkg, rss_ctrl, rss_datapath (and rss_ram through it).
//
//   channel   ports                         word
//   input     req_valid req_stall req_word  flags, Q8.16 ratio, last marker
//   result    rsp_valid rsp_stall rsp_word  metric code, Q15.16 value, final
//
// Experiments load one word per cycle. After the last word the block stalls
// input while it works: with n >= 2 kept samples, five or six serial divisions
// (four for one sample, two for none), a serial square root, one variance pass
// and 8 ranks of 24 radix counting passes, through the RAM read port.
// Then 13 result words follow, one per cycle while not stalled.
// Reset clears the counters; the sample RAM is not cleared.
`timescale 1ns / 1ps

module ratio_summary_statistics #(
   parameter int MAX_SAMPLES = 1024,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rss_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rss_pkg::rsp_word_type rsp_word
);

   rss_pkg::cmd_type    cmd;
   rss_pkg::status_type status;

   rss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_word.last_item),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rss_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .status   (status),
      .rsp_word (rsp_word)
   );

endmodule

// ----- design/rss_checker.sv -----
// Port-level assertions for ratio_summary_statistics, with bind.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input rss_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rss_pkg::rsp_word_type rsp_word
);

   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while emitting");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_word.last_item) |=> req_stall)
      else $error("input not stalled after last word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

   a_code_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_word.final_metric) |=>
      (rsp_valid && rsp_word.metric_code == 4'($past(rsp_word.metric_code) + 4'd1)))
      else $error("metric codes out of sequence");

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_word.final_metric) |=> (!rsp_valid && !req_stall))
      else $error("block did not return to loading");

endmodule

bind ratio_summary_statistics rss_checker u_rss_checker (.*);

// ----- tb/tb_ratio_summary_statistics.sv -----
// Testbench for ratio_summary_statistics: drives experiment words, predicts the
// 13 metric words of each run and compares them in order. Depends on rss_pkg.
`timescale 1ns / 1ps

module tb_ratio_summary_statistics;

   localparam int MAXS = 1024;
   localparam int FB   = 16;
   localparam int NROWS = 14;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rss_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rss_pkg::rsp_word_type rsp_word;

   ratio_summary_statistics uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [23:0] kept [MAXS];
   int unsigned kept_n, exp_n, wins1, wins2, above_n;
   longint unsigned ratio_sum;
   rss_pkg::rsp_word_type metric_q [$];
   int errors = 0;
   bit quiet_tx = 0, quiet_rx = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint sat_32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned win_rate(int unsigned w, int unsigned t);
      if (t == 0) return 0;
      return ((longint'(w) << FB) + t / 2) / t;
   endfunction

   task automatic predict_experiment(rss_pkg::req_word_type w);
      longint v [13];
      longint one, m, s, num, q;
      longint unsigned m2, mag, pos;
      logic [23:0] srt [$];
      int unsigned n, lesser, lo, k, qi;
      one = longint'(1) << FB;
      if (exp_n < 65535) exp_n++;
      if (w.clustered_ok && wins1 < 65535) wins1++;
      if (w.grid_ok && wins2 < 65535) wins2++;
      if (w.clustered_ok && w.grid_ok && w.ratio_value != 0 && kept_n < MAXS) begin
         kept[kept_n] = w.ratio_value;
         kept_n++;
         ratio_sum += w.ratio_value;
         if (w.ratio_value > 24'h010000) above_n++;
      end
      if (!w.last_item) return;
      n = kept_n;
      v[0] = exp_n;
      v[1] = n;
      v[2] = win_rate(wins1, exp_n);
      v[3] = win_rate(wins2, exp_n);
      if (n == 0) begin
         for (int i = 4; i <= 10; i++) v[i] = -one;
         v[11] = one;
         v[12] = 0;
      end else begin
         m = (ratio_sum + n / 2) / n;
         s = 0;
         if (n >= 2) begin
            m2 = 0;
            for (int i = 0; i < n; i++) begin
               num = longint'(kept[i]) - m;
               m2 += num * num;
            end
            s = int_sqrt(m2 / (n - 1));
         end
         for (int i = 0; i < n; i++) srt.insert(srt.size(), kept[i]);
         srt.sort();
         v[4] = m;
         v[5] = s;
         if (n[0]) v[6] = srt[n / 2];
         else v[6] = (longint'(srt[n / 2 - 1]) + srt[n / 2] + 1) >> 1;
         v[7] = srt[0];
         v[8] = srt[n - 1];
         for (qi = 1; qi <= 3; qi += 2) begin
            pos = qi * (n - 1);
            lo = pos >> 2;
            k = pos & 3;
            v[qi == 1 ? 9 : 10] = (longint'(srt[lo]) * (4 - k) +
               (k != 0 ? longint'(srt[lo + 1]) : longint'(srt[lo])) * k + 2) >> 2;
         end
         lesser = (above_n < n - above_n) ? above_n : n - above_n;
         v[11] = ((longint'(2 * lesser) << FB) + n / 2) / n;
         if (s == 0) begin
            v[12] = 0;
         end else begin
            num = (one - m) * one;
            mag = num < 0 ? -num : num;
            q = (mag + s / 2) / s;
            v[12] = sat_32(num < 0 ? -q : q);
         end
      end
      for (int i = 0; i < 13; i++) begin
         rss_pkg::rsp_word_type r;
         r.metric_code = 4'(i);
         r.metric_value = 32'(sat_32(v[i]));
         r.final_metric = (i == 12);
         metric_q.insert(metric_q.size(), r);
      end
      kept_n = 0; exp_n = 0; wins1 = 0; wins2 = 0; above_n = 0; ratio_sum = 0;
   endtask

   // response checker and stall generator
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (metric_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", rsp_word);
         end else if (metric_q[0] !== rsp_word) begin
            errors++;
            if (errors <= 10)
               $display("mismatch code %0d: expected %h got %h",
                        metric_q[0].metric_code, metric_q[0], rsp_word);
            void'(metric_q.pop_front());
         end else begin
            void'(metric_q.pop_front());
         end
      end
      rsp_stall <= quiet_rx ? 1'b0 : ($urandom_range(99) < 8);
   end

   // directed rows: word plus an optional typed-in value for the run's mean
   typedef struct {
      rss_pkg::req_word_type w;
      bit has_mean;
      logic signed [31:0] mean;
   } row_type;
   row_type rows [NROWS];

   function automatic rss_pkg::req_word_type mk(bit c, bit g, logic [23:0] r, bit l);
      rss_pkg::req_word_type w;
      w.clustered_ok = c; w.grid_ok = g; w.ratio_value = r; w.last_item = l;
      return w;
   endfunction

   task automatic send(rss_pkg::req_word_type w);
      while (!quiet_tx && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_experiment(w);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (metric_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int len;
      bit c, g;
      logic [23:0] r;
      kept_n = 0; exp_n = 0; wins1 = 0; wins2 = 0; above_n = 0; ratio_sum = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // no samples: sentinel statistics
      rows[0]  = '{mk(1, 0, 24'h0, 1), 1, -32'sh10000};
      // one sample of maximum ratio
      rows[1]  = '{mk(1, 1, 24'hFFFFFF, 1), 1, 32'shFFFFFF};
      // zero ratio with both flags is not kept
      rows[2]  = '{mk(1, 1, 24'h0, 0), 0, 0};
      rows[3]  = '{mk(0, 1, 24'h1, 0), 0, 0};
      rows[4]  = '{mk(1, 1, 24'h000001, 0), 0, 0};
      rows[5]  = '{mk(1, 1, 24'h010000, 0), 0, 0};
      rows[6]  = '{mk(1, 1, 24'h010001, 1), 0, 0};
      // equal samples: zero std, zero effect
      rows[7]  = '{mk(1, 1, 24'h020000, 0), 0, 0};
      rows[8]  = '{mk(1, 1, 24'h020000, 1), 1, 32'sh20000};
      rows[9]  = '{mk(1, 1, 24'h8000, 0), 0, 0};
      rows[10] = '{mk(1, 1, 24'h30000, 0), 0, 0};
      rows[11] = '{mk(1, 1, 24'hABCDEF, 0), 0, 0};
      rows[12] = '{mk(1, 1, 24'h555555, 0), 0, 0};
      rows[13] = '{mk(0, 0, 24'hAAAAAA, 1), 0, 0};
      foreach (rows[i]) begin
         send(rows[i].w);
         if (rows[i].has_mean && metric_q.size() >= 9 &&
             metric_q[metric_q.size() - 9].metric_value !== rows[i].mean) begin
            errors++;
            if (errors <= 10)
               $display("row %0d: expected mean %h predicted %h", i, rows[i].mean,
                        metric_q[metric_q.size() - 9].metric_value);
         end
      end
      drain;
      // random runs, first without idling
      quiet_tx = 1; quiet_rx = 1;
      for (int run = 0; run < 12; run++) begin
         if (run == 4) begin
            quiet_tx = 0; quiet_rx = 0;
         end
         len = (run == 7) ? 1 : int'($urandom_range(14, 1));
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) < 7) begin
               c = 1; g = 1;
            end else begin
               c = 1'($urandom_range(1)); g = 1'($urandom_range(1));
            end
            case ($urandom_range(3))
               0: r = 24'($urandom_range(24'h20000, 24'h1));
               1: r = 24'($urandom);
               2: r = 24'(24'h10000 + $urandom_range(2) - 1);
               default: r = 24'($urandom_range(24'h1FFFF));
            endcase
            send(mk(c, g, r, i == len - 1));
         end
         if (run == 5) drain;
      end
      drain;
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
